// ===== rtl/core/ilm_pkg.sv =====
// ============================================================================
// ilm_pkg - shared types and constants of the level meter
// Transaction structs, datapath command codes, status struct and the
// fixed-point helpers of the IEC scale.
// ============================================================================
`default_nettype none

package ilm_pkg;

    localparam int DEF_LEVEL_BITS      = 12;
    localparam int DEF_DECAY_FRAC_BITS = 32;

    localparam logic [11:0] FULL_SCALE_RST   = 12'd217;
    localparam logic [7:0]  PEAK_FALLOFF_RST = 8'd16;

    // Configuration register indexes.
    localparam logic CFG_FULL_SCALE   = 1'b0;
    localparam logic CFG_PEAK_FALLOFF = 1'b1;

    // Input commands.
    localparam logic CMD_FRAME      = 1'b0;
    localparam logic CMD_PEAK_RESET = 1'b1;

    // Colour zones.
    localparam logic [2:0] ZONE_OVER = 3'd0;
    localparam logic [2:0] ZONE_0DB  = 3'd1;
    localparam logic [2:0] ZONE_M3   = 3'd2;
    localparam logic [2:0] ZONE_M6   = 3'd3;

    // dB limits in Q8.8.
    localparam logic signed [15:0] DB_MIN     = -16'sd17920;
    localparam logic signed [15:0] DB_MAX     = 16'sd1024;
    localparam logic [15:0]        DB_MIN_MAG = 16'd17920;
    localparam logic [15:0]        DB_MAX_MAG = 16'd1024;

    // 20*log10(2) in Q16 and the reciprocal of 25 in Q22.
    localparam logic [31:0] DB20_LOG2_Q16 = 32'd394566;
    localparam logic [31:0] RECIP25_Q22   = 32'd167772;
    localparam logic [31:0] DIV25         = 32'd25;

    typedef struct packed {
        logic        cmd;
        logic [23:0] amplitude;
    } t_in_item;

    typedef struct packed {
        logic [11:0] bar_level;
        logic [11:0] peak_level;
        logic [2:0]  bar_zone;
        logic [2:0]  peak_zone;
        logic        over;
    } t_out_item;

    typedef logic [4:0] t_op;

    localparam t_op OP_NONE   = 5'd0;
    localparam t_op OP_LOAD   = 5'd1;
    localparam t_op OP_NSET   = 5'd2;
    localparam t_op OP_L1     = 5'd3;
    localparam t_op OP_L2     = 5'd4;
    localparam t_op OP_L3     = 5'd5;
    localparam t_op OP_L4     = 5'd6;
    localparam t_op OP_NORM   = 5'd7;
    localparam t_op OP_ALIGN  = 5'd8;
    localparam t_op OP_SQ     = 5'd9;
    localparam t_op OP_DBM    = 5'd10;
    localparam t_op OP_DBC    = 5'd11;
    localparam t_op OP_DBZ    = 5'd12;
    localparam t_op OP_DBN    = 5'd13;
    localparam t_op OP_BARSET = 5'd14;
    localparam t_op OP_MST    = 5'd15;
    localparam t_op OP_MSTEP  = 5'd16;
    localparam t_op OP_BARUPD = 5'd17;
    localparam t_op OP_BDWR   = 5'd18;
    localparam t_op OP_PKCLR  = 5'd19;
    localparam t_op OP_ZONE   = 5'd20;
    localparam t_op OP_PKSET  = 5'd21;
    localparam t_op OP_PKWAIT = 5'd22;
    localparam t_op OP_PKUPD  = 5'd23;
    localparam t_op OP_PDWR   = 5'd24;
    localparam t_op OP_OUT    = 5'd25;

    // Level targets for the scale unit.
    localparam logic [2:0] SEL_SIGNAL = 3'd0;
    localparam logic [2:0] SEL_THR_0  = 3'd1;
    localparam logic [2:0] SEL_THR_M3 = 3'd2;
    localparam logic [2:0] SEL_THR_M6 = 3'd3;
    localparam logic [2:0] SEL_THR_M10 = 3'd4;

    // Operand pairs for the decay multiplier.
    localparam logic [2:0] MS_BAR  = 3'd0;
    localparam logic [2:0] MS_BDEC = 3'd1;
    localparam logic [2:0] MS_PEAK = 3'd2;
    localparam logic [2:0] MS_PDEC = 3'd3;

    typedef struct packed {
        t_op        op;
        logic [2:0] sel;
    } t_dp_cmd;

    typedef struct packed {
        logic is_peak_reset;
        logic amp_zero;
        logic norm_done;
        logic mul_done;
        logic mul_lt;
        logic bar_lt;
        logic pk_lt;
        logic wait_gt;
    } t_dp_status;

    // Scale numerator for the fixed dB points of the zone thresholds.
    function automatic logic [16:0] thr_n(input logic [2:0] sel);
        logic [16:0] n;
        n = 17'd0;
        unique case (sel)
            SEL_THR_0:   n = 17'd102400;
            SEL_THR_M3:  n = 17'd94720;
            SEL_THR_M6:  n = 17'd87040;
            SEL_THR_M10: n = 17'd76800;
            default:     n = 17'd0;
        endcase
        return n;
    endfunction

    // Piecewise-linear IEC scale: dB in Q8.8 to a numerator over 102400.
    function automatic logic [16:0] iec_n(input logic signed [15:0] d);
        logic signed [31:0] dv;
        logic signed [31:0] n;
        dv = 32'(d);
        if (dv < -32'sd15360) begin
            n = dv + 32'sd17920;
        end else if (dv < -32'sd12800) begin
            n = 32'sd2 * (dv + 32'sd15360) + 32'sd2560;
        end else if (dv < -32'sd10240) begin
            n = 32'sd3 * (dv + 32'sd12800) + 32'sd7680;
        end else if (dv < -32'sd7680) begin
            n = 32'sd6 * (dv + 32'sd10240) + 32'sd15360;
        end else if (dv < -32'sd5120) begin
            n = 32'sd8 * (dv + 32'sd7680) + 32'sd30720;
        end else begin
            n = 32'sd10 * (dv + 32'sd5120) + 32'sd51200;
        end
        if (n < 32'sd0) begin
            n = 32'sd0;
        end
        return n[16:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ilm_dp.sv =====
// ============================================================================
// ilm_dp - level meter datapath
// Holds the meter state and runs the log, scale and decay arithmetic one
// command per cycle: a shared 32x32 multiplier and a radix-16 serial
// multiplier for the fractional decay products.
// ============================================================================
`default_nettype none

module ilm_dp #(
    parameter int DECAY_FRAC_BITS = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic               i_cfg_index,
    input  wire logic [11:0]        i_cfg_wdata,
    input  ilm_pkg::t_in_item       i_in_data,
    input  ilm_pkg::t_dp_cmd        i_cmd,
    output ilm_pkg::t_dp_status     o_status,
    output ilm_pkg::t_out_item      o_out_data
);
    import ilm_pkg::*;

    localparam int LB  = DEF_LEVEL_BITS;
    localparam int F   = DECAY_FRAC_BITS;
    localparam int DIG = (F + 3) / 4;
    localparam int MCW = $clog2(DIG + 1);

    localparam logic [LB-1:0]  LEVEL_MAX = '1;
    localparam logic [31:0]    LEVEL_MAX32 = 32'(LEVEL_MAX);
    localparam logic [F-1:0]   BAR_RATE = F'((64'd1 << F) - ((64'd3 << F) + 64'd50) / 64'd100);
    localparam logic [F-1:0]   PEAK_RATE =
        F'((64'd1 << F) - ((64'd3 << F) + 64'd500000) / 64'd1000000);
    localparam logic [MCW-1:0] DIG_CNT = MCW'(DIG);

    logic [11:0]        r_fs;
    logic [7:0]         r_falloff;
    logic               r_cmd;
    logic               r_amp_zero;
    logic [31:0]        r_m;
    logic [4:0]         r_e;
    logic [15:0]        r_frac;
    logic               r_neg;
    logic [39:0]        r_prod;
    logic signed [15:0] r_d;
    logic [16:0]        r_n;
    logic [16:0]        r_y;
    logic [12:0]        r_q0;
    logic [LB-1:0]      r_thr [1:4];
    logic [LB-1:0]      r_level;
    logic [LB-1:0]      r_bar;
    logic [F-1:0]       r_bdec;
    logic [LB-1:0]      r_peak;
    logic [8:0]         r_wait;
    logic [F-1:0]       r_pdec;
    logic [2:0]         r_pzone;
    logic [2:0]         r_bzone;
    logic               r_over;
    logic [2*F-1:0]     r_ma;
    logic [F-1:0]       r_mb;
    logic [2*F-1:0]     r_acc;
    logic [MCW-1:0]     r_mcnt;
    t_out_item          r_out;

    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        mul_p;
    logic [31:0]        sq_t;
    logic               e_top;
    logic [20:0]        mag;
    logic [15:0]        db_t;
    logic signed [15:0] db_val;
    logic [16:0]        y_new;
    logic [12:0]        q0_new;
    logic [16:0]        rem;
    logic [13:0]        lvq;
    logic [LB-1:0]      lv;
    logic [F-1:0]       mres;
    logic [LB-1:0]      mres_lv;
    logic               mul_lt;
    logic [2*F-1:0]     mstep;
    logic [2:0]         zone;
    logic [LB-1:0]      pt_over;

    assign e_top  = (r_e == 5'd23);
    assign mag    = e_top ? 21'(r_frac) : (21'({5'd23 - r_e, 16'd0}) - 21'(r_frac));
    assign y_new  = r_prod[28:12];
    assign q0_new = r_prod[34:22];

    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        unique case (i_cmd.op)
            OP_SQ: begin
                mul_a = r_m;
                mul_b = r_m;
            end
            OP_DBM: begin
                mul_a = 32'(mag);
                mul_b = DB20_LOG2_Q16;
            end
            OP_L1: begin
                mul_a = 32'(r_n);
                mul_b = 32'(r_fs);
            end
            OP_L2: begin
                mul_a = 32'(y_new);
                mul_b = RECIP25_Q22;
            end
            OP_L3: begin
                mul_a = 32'(q0_new);
                mul_b = DIV25;
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);
    assign sq_t  = mul_p[61:30];

    // Truncation toward zero: the magnitude is shifted, then the sign applied.
    assign db_t = r_prod[39:24];
    always_comb begin
        if (r_neg) begin
            db_val = (db_t > DB_MIN_MAG) ? DB_MIN : -$signed(db_t);
        end else begin
            db_val = (db_t > DB_MAX_MAG) ? DB_MAX : $signed(db_t);
        end
    end

    // Quotient estimate by reciprocal is at most one low; one compare fixes it.
    assign rem = r_y - r_prod[16:0];
    assign lvq = 14'(r_q0) + ((rem >= 17'd25) ? 14'd1 : 14'd0);
    assign lv  = (32'(lvq) > LEVEL_MAX32) ? LEVEL_MAX : LB'(lvq);

    assign mres    = r_acc[2*F-1:F];
    assign mres_lv = LB'(mres);
    assign mul_lt  = (mres < F'(r_level));
    assign mstep   = r_acc + (2*F)'(r_ma * (2*F)'(r_mb[3:0]));

    always_comb begin
        if (r_level < r_thr[4]) begin
            zone    = ZONE_M6;
            pt_over = r_thr[4];
        end else if (r_level < r_thr[3]) begin
            zone    = ZONE_M3;
            pt_over = r_thr[3];
        end else if (r_level < r_thr[2]) begin
            zone    = ZONE_0DB;
            pt_over = r_thr[2];
        end else begin
            zone    = ZONE_OVER;
            pt_over = r_thr[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs      <= FULL_SCALE_RST;
            r_falloff <= PEAK_FALLOFF_RST;
            r_bar     <= '0;
            r_bdec    <= BAR_RATE;
            r_peak    <= '0;
            r_wait    <= '0;
            r_pdec    <= PEAK_RATE;
            r_pzone   <= ZONE_M6;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_FULL_SCALE:   r_fs      <= i_cfg_wdata;
                    CFG_PEAK_FALLOFF: r_falloff <= i_cfg_wdata[7:0];
                    default:          r_fs      <= r_fs;
                endcase
            end
            unique case (i_cmd.op)
                OP_LOAD: begin
                    r_cmd      <= i_in_data.cmd;
                    r_amp_zero <= (i_in_data.amplitude == 24'd0);
                    r_m        <= {8'd0, i_in_data.amplitude};
                    r_e        <= 5'd23;
                    r_frac     <= 16'd0;
                end
                OP_NSET: r_n <= thr_n(i_cmd.sel);
                OP_L1:   r_prod <= mul_p[39:0];
                OP_L2: begin
                    r_y    <= y_new;
                    r_prod <= mul_p[39:0];
                end
                OP_L3: begin
                    r_q0   <= q0_new;
                    r_prod <= mul_p[39:0];
                end
                OP_L4: begin
                    unique case (i_cmd.sel)
                        SEL_THR_0:   r_thr[1] <= lv;
                        SEL_THR_M3:  r_thr[2] <= lv;
                        SEL_THR_M6:  r_thr[3] <= lv;
                        SEL_THR_M10: r_thr[4] <= lv;
                        default:     r_level  <= lv;
                    endcase
                end
                OP_NORM: begin
                    if (!r_m[23]) begin
                        r_m <= r_m << 1;
                        r_e <= r_e - 5'd1;
                    end
                end
                OP_ALIGN: r_m <= r_m << 7;
                OP_SQ: begin
                    if (sq_t[31]) begin
                        r_m    <= {1'b0, sq_t[31:1]};
                        r_frac <= {r_frac[14:0], 1'b1};
                    end else begin
                        r_m    <= sq_t;
                        r_frac <= {r_frac[14:0], 1'b0};
                    end
                end
                OP_DBM: begin
                    r_neg  <= !e_top;
                    r_prod <= mul_p[39:0];
                end
                OP_DBC: r_d <= db_val;
                OP_DBZ: r_d <= DB_MIN;
                OP_DBN: r_n <= iec_n(r_d);
                OP_BARSET: begin
                    r_bar  <= r_level;
                    r_bdec <= BAR_RATE;
                end
                OP_MST: begin
                    unique case (i_cmd.sel)
                        MS_BAR: begin
                            r_ma <= (2*F)'(r_bdec);
                            r_mb <= F'(r_bar);
                        end
                        MS_BDEC: begin
                            r_ma <= (2*F)'(r_bdec);
                            r_mb <= r_bdec;
                        end
                        MS_PEAK: begin
                            r_ma <= (2*F)'(r_pdec);
                            r_mb <= F'(r_peak);
                        end
                        default: begin
                            r_ma <= (2*F)'(r_pdec);
                            r_mb <= r_pdec;
                        end
                    endcase
                    r_acc  <= '0;
                    r_mcnt <= DIG_CNT;
                end
                OP_MSTEP: begin
                    r_acc  <= mstep;
                    r_ma   <= r_ma << 4;
                    r_mb   <= r_mb >> 4;
                    r_mcnt <= r_mcnt - MCW'(1);
                end
                OP_BARUPD: begin
                    if (mul_lt) begin
                        r_bar <= r_level;
                    end else begin
                        r_bar   <= mres_lv;
                        r_level <= mres_lv;
                    end
                end
                OP_BDWR: r_bdec <= mres;
                OP_PKCLR: begin
                    r_peak  <= '0;
                    r_level <= r_bar;
                end
                OP_ZONE: begin
                    r_bzone <= zone;
                    r_over  <= (r_level > pt_over);
                end
                OP_PKSET: begin
                    r_peak  <= r_level;
                    r_wait  <= '0;
                    r_pdec  <= PEAK_RATE;
                    r_pzone <= r_bzone;
                end
                OP_PKWAIT: begin
                    if (r_wait != 9'h1FF) begin
                        r_wait <= r_wait + 9'd1;
                    end
                end
                OP_PKUPD: begin
                    if (mul_lt) begin
                        r_peak <= r_level;
                    end else begin
                        r_peak <= mres_lv;
                        if (mres_lv < r_thr[4]) begin
                            r_pzone <= ZONE_M6;
                        end
                    end
                end
                OP_PDWR: r_pdec <= mres;
                OP_OUT: begin
                    r_out.bar_level  <= 12'(r_level);
                    r_out.peak_level <= 12'(r_peak);
                    r_out.bar_zone   <= r_bzone;
                    r_out.peak_zone  <= r_pzone;
                    r_out.over       <= r_over;
                end
                default: begin
                    r_m <= r_m;
                end
            endcase
        end
    end

    assign o_status.is_peak_reset = (r_cmd == CMD_PEAK_RESET);
    assign o_status.amp_zero      = r_amp_zero;
    assign o_status.norm_done     = r_m[23];
    assign o_status.mul_done      = (r_mcnt == '0);
    assign o_status.mul_lt        = mul_lt;
    assign o_status.bar_lt        = (r_bar < r_level);
    assign o_status.pk_lt         = (r_peak < r_level);
    assign o_status.wait_gt       = (r_wait > {1'b0, r_falloff});

    assign o_out_data = r_out;

endmodule

`default_nettype wire

// ===== rtl/core/ilm_ctrl.sv =====
// ============================================================================
// ilm_ctrl - level meter sequencer
// Steps the datapath through thresholds, log, scale, bar hold and peak hold
// for one transaction, and owns the input stall and the output valid.
// ============================================================================
`default_nettype none

module ilm_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    input  ilm_pkg::t_dp_status  i_status,
    output ilm_pkg::t_dp_cmd     o_cmd
);
    import ilm_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_NSET   = 5'd1;
    localparam logic [4:0] S_L1     = 5'd2;
    localparam logic [4:0] S_L2     = 5'd3;
    localparam logic [4:0] S_L3     = 5'd4;
    localparam logic [4:0] S_L4     = 5'd5;
    localparam logic [4:0] S_NORM   = 5'd6;
    localparam logic [4:0] S_ALIGN  = 5'd7;
    localparam logic [4:0] S_SQ     = 5'd8;
    localparam logic [4:0] S_DBM    = 5'd9;
    localparam logic [4:0] S_DBC    = 5'd10;
    localparam logic [4:0] S_DBZ    = 5'd11;
    localparam logic [4:0] S_DBN    = 5'd12;
    localparam logic [4:0] S_BAR    = 5'd13;
    localparam logic [4:0] S_BMUL   = 5'd14;
    localparam logic [4:0] S_BDST   = 5'd15;
    localparam logic [4:0] S_BDSQ   = 5'd16;
    localparam logic [4:0] S_PKCLR  = 5'd17;
    localparam logic [4:0] S_ZONE   = 5'd18;
    localparam logic [4:0] S_PEAK   = 5'd19;
    localparam logic [4:0] S_PWAIT  = 5'd20;
    localparam logic [4:0] S_PMUL   = 5'd21;
    localparam logic [4:0] S_PDST   = 5'd22;
    localparam logic [4:0] S_PDSQ   = 5'd23;
    localparam logic [4:0] S_OUT    = 5'd24;

    logic [4:0] r_state;
    logic [4:0] n_state;
    logic [2:0] r_k;
    logic [2:0] n_k;
    logic [3:0] r_cnt;
    logic [3:0] n_cnt;
    logic       r_ovalid;
    logic       n_ovalid;

    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_cnt     = r_cnt;
        o_cmd.op  = OP_NONE;
        o_cmd.sel = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_k      = SEL_THR_0;
                    n_state  = S_NSET;
                end
            end
            S_NSET: begin
                o_cmd.op = OP_NSET;
                n_state  = S_L1;
            end
            S_L1: begin
                o_cmd.op = OP_L1;
                n_state  = S_L2;
            end
            S_L2: begin
                o_cmd.op = OP_L2;
                n_state  = S_L3;
            end
            S_L3: begin
                o_cmd.op = OP_L3;
                n_state  = S_L4;
            end
            S_L4: begin
                o_cmd.op = OP_L4;
                if (r_k == SEL_SIGNAL) begin
                    n_state = S_BAR;
                end else if (r_k == SEL_THR_M10) begin
                    n_k = SEL_SIGNAL;
                    priority if (i_status.is_peak_reset) begin
                        n_state = S_PKCLR;
                    end else if (i_status.amp_zero) begin
                        n_state = S_DBZ;
                    end else begin
                        n_state = S_NORM;
                    end
                end else begin
                    n_k     = r_k + 3'd1;
                    n_state = S_NSET;
                end
            end
            S_NORM: begin
                o_cmd.op = OP_NORM;
                if (i_status.norm_done) begin
                    n_state = S_ALIGN;
                end
            end
            S_ALIGN: begin
                o_cmd.op = OP_ALIGN;
                n_cnt    = 4'd0;
                n_state  = S_SQ;
            end
            S_SQ: begin
                o_cmd.op = OP_SQ;
                n_cnt    = r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    n_state = S_DBM;
                end
            end
            S_DBM: begin
                o_cmd.op = OP_DBM;
                n_state  = S_DBC;
            end
            S_DBC: begin
                o_cmd.op = OP_DBC;
                n_state  = S_DBN;
            end
            S_DBZ: begin
                o_cmd.op = OP_DBZ;
                n_state  = S_DBN;
            end
            S_DBN: begin
                o_cmd.op = OP_DBN;
                n_state  = S_L1;
            end
            S_BAR: begin
                o_cmd.sel = MS_BAR;
                if (i_status.bar_lt) begin
                    o_cmd.op = OP_BARSET;
                    n_state  = S_ZONE;
                end else begin
                    o_cmd.op = OP_MST;
                    n_state  = S_BMUL;
                end
            end
            S_BMUL: begin
                if (!i_status.mul_done) begin
                    o_cmd.op = OP_MSTEP;
                end else begin
                    o_cmd.op = OP_BARUPD;
                    n_state  = i_status.mul_lt ? S_ZONE : S_BDST;
                end
            end
            S_BDST: begin
                o_cmd.op  = OP_MST;
                o_cmd.sel = MS_BDEC;
                n_state   = S_BDSQ;
            end
            S_BDSQ: begin
                if (!i_status.mul_done) begin
                    o_cmd.op = OP_MSTEP;
                end else begin
                    o_cmd.op = OP_BDWR;
                    n_state  = S_ZONE;
                end
            end
            S_PKCLR: begin
                o_cmd.op = OP_PKCLR;
                n_state  = S_ZONE;
            end
            S_ZONE: begin
                o_cmd.op = OP_ZONE;
                n_state  = i_status.is_peak_reset ? S_OUT : S_PEAK;
            end
            S_PEAK: begin
                if (i_status.pk_lt) begin
                    o_cmd.op = OP_PKSET;
                    n_state  = S_OUT;
                end else begin
                    o_cmd.op = OP_PKWAIT;
                    n_state  = S_PWAIT;
                end
            end
            S_PWAIT: begin
                if (i_status.wait_gt) begin
                    o_cmd.op  = OP_MST;
                    o_cmd.sel = MS_PEAK;
                    n_state   = S_PMUL;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_PMUL: begin
                if (!i_status.mul_done) begin
                    o_cmd.op = OP_MSTEP;
                end else begin
                    o_cmd.op = OP_PKUPD;
                    n_state  = i_status.mul_lt ? S_OUT : S_PDST;
                end
            end
            S_PDST: begin
                o_cmd.op  = OP_MST;
                o_cmd.sel = MS_PDEC;
                n_state   = S_PDSQ;
            end
            S_PDSQ: begin
                if (!i_status.mul_done) begin
                    o_cmd.op = OP_MSTEP;
                end else begin
                    o_cmd.op = OP_PDWR;
                    n_state  = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ovalid || !i_out_stall) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_ovalid = (o_cmd.op == OP_OUT) || (r_ovalid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_k      <= SEL_SIGNAL;
            r_cnt    <= 4'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;

endmodule

`default_nettype wire

// ===== rtl/core/iec_level_meter_peak_hold.sv =====
// ============================================================================
// iec_level_meter_peak_hold - one-channel IEC level meter with peak hold
// Converts a linear amplitude to a bar length on the IEC scale and keeps a
// decaying bar hold and a delayed, decaying peak marker.
// ============================================================================
// Usage:
// The input channel (i_in_valid, o_in_stall, i_in_data) carries one
// transaction per display frame: cmd 0 updates the meter with an amplitude,
// cmd 1 clears the peak marker. The output channel (o_out_valid,
// i_out_stall, o_out_data) returns exactly one result transaction for each
// input transaction, in order.
// The block works on one transaction at a time. A frame update runs four
// zone thresholds, up to 24 normalization steps, 16 squaring steps of the
// log unit, and up to four decay products on the serial multiplier. A peak
// clear runs the zone thresholds but skips the log unit and decay products.
// A finished result sits in an output register, so the next transaction is
// taken while the result still waits; if the receiver stalls, the block
// holds the next result until that register is free and keeps o_in_stall
// high meanwhile. Configuration writes are taken at any edge with
// i_cfg_wr_en high. Synchronous reset restores the register defaults
// (full scale 217, peak falloff 16), clears both holds and drops o_out_valid.
// ============================================================================
`default_nettype none

module iec_level_meter_peak_hold #(
    parameter int DECAY_FRAC_BITS = ilm_pkg::DEF_DECAY_FRAC_BITS
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_wr_en,
    input  wire logic           i_cfg_index,
    input  wire logic [11:0]    i_cfg_wdata,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  ilm_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output ilm_pkg::t_out_item  o_out_data
);
    import ilm_pkg::*;

    // Commands flow from the sequencer to the datapath, status flows back.
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    ilm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    // The datapath captures the input transaction when the sequencer issues
    // its load command, which happens only in the accepting cycle.
    ilm_dp #(
        .DECAY_FRAC_BITS (DECAY_FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== rtl/core/ilm_checker.sv =====
// ============================================================================
// ilm_checker - port-level checks of the level meter
// Watches the top-level channels and is bound to every instance.
// ============================================================================
`default_nettype none

module ilm_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          o_in_stall,
    input wire logic          o_out_valid,
    input wire logic          i_out_stall,
    input ilm_pkg::t_out_item o_out_data
);
    import ilm_pkg::*;

    // One transaction at a time: an accepted input stalls the next cycle.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while a transaction was in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    a_zone_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.bar_zone <= ZONE_M6 && o_out_data.peak_zone <= ZONE_M6))
        else $error("zone out of range");

    a_over_zone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.over) |-> (o_out_data.bar_zone == ZONE_OVER))
        else $error("over flag outside the over zone");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind iec_level_meter_peak_hold ilm_checker u_ilm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
